FILE: src/sha256_pkg.sv
package sha256_pkg;

   localparam int WORD_W   = 32;
   localparam int NUM_HASH = 8;
   localparam int WIN_LEN  = 16;

   localparam logic [7:0] PAD_BYTE   = 8'h80;
   localparam logic [5:0] LEN_FILL   = 6'd56;
   localparam logic [5:0] LAST_FILL  = 6'd63;
   localparam logic [5:0] LAST_ROUND = 6'd63;
   localparam logic [2:0] LAST_WORD  = 3'd7;

   localparam logic [31:0] HASH_INIT [0:7] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [31:0] ROUND_K [0:63] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_present;
      logic       end_of_message;
   } req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } rsp_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_PAD_80,
      S_PAD_ZERO,
      S_PAD_LEN,
      S_COMPRESS,
      S_UPDATE,
      S_OUTPUT
   } state_type;

   typedef enum logic [1:0] {
      BSEL_MSG,
      BSEL_PAD80,
      BSEL_ZERO,
      BSEL_LEN
   } byte_sel_type;

   typedef struct packed {
      logic         push;
      byte_sel_type byte_sel;
      logic         count_inc;
      logic         load_work;
      logic         round_en;
      logic [5:0]   round;
      logic         hash_update;
      logic         clear;
      logic [2:0]   word;
   } cmd_type;

   typedef struct packed {
      logic [5:0] fill;
   } status_type;

endpackage

FILE: src/sha256_dp.sv
module sha256_dp (
   input  logic                   clock,
   input  logic                   reset,
   input  sha256_pkg::cmd_type    cmd,
   input  logic [7:0]             msg_byte,
   output sha256_pkg::status_type status,
   output sha256_pkg::rsp_type    rsp_item
);
   import sha256_pkg::*;

   logic [31:0] hash_ff [0:NUM_HASH-1];
   logic [31:0] work_ff [0:NUM_HASH-1];
   logic [31:0] win_ff  [0:WIN_LEN-1];
   logic [23:0] acc_ff;
   logic [5:0]  fill_ff;
   logic [63:0] count_ff;

   logic [7:0]  push_byte;
   logic [31:0] packed_word;
   logic [63:0] len_bits;
   logic [63:0] len_shift;
   logic [31:0] sched_new;
   logic [31:0] t1;
   logic [31:0] t2;

   function automatic logic [31:0] rotr(input logic [31:0] x, input int s);
      return (x >> s) | (x << (32 - s));
   endfunction

   // message length in bits, sent big-endian one byte per pad slot 56..63
   assign len_bits  = {count_ff[60:0], 3'b000};
   assign len_shift = len_bits >> {~fill_ff[2:0], 3'b000};

   always_comb begin
      case (cmd.byte_sel)
         BSEL_MSG:   push_byte = msg_byte;
         BSEL_PAD80: push_byte = PAD_BYTE;
         BSEL_ZERO:  push_byte = 8'h00;
         BSEL_LEN:   push_byte = len_shift[7:0];
         default:    push_byte = 8'h00;
      endcase
   end

   assign packed_word = {acc_ff, push_byte};

   // W[t+16] from the rolling window; W[t] sits in slot 0
   assign sched_new = (rotr(win_ff[14], 17) ^ rotr(win_ff[14], 19) ^ (win_ff[14] >> 10))
                    + win_ff[9]
                    + (rotr(win_ff[1], 7) ^ rotr(win_ff[1], 18) ^ (win_ff[1] >> 3))
                    + win_ff[0];

   assign t1 = work_ff[7]
             + (rotr(work_ff[4], 6) ^ rotr(work_ff[4], 11) ^ rotr(work_ff[4], 25))
             + ((work_ff[4] & work_ff[5]) ^ (~work_ff[4] & work_ff[6]))
             + ROUND_K[cmd.round] + win_ff[0];
   assign t2 = (rotr(work_ff[0], 2) ^ rotr(work_ff[0], 13) ^ rotr(work_ff[0], 22))
             + ((work_ff[0] & work_ff[1]) ^ (work_ff[0] & work_ff[2])
                ^ (work_ff[1] & work_ff[2]));

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         fill_ff  <= '0;
         count_ff <= '0;
         for (int i = 0; i < NUM_HASH; i++) begin
            hash_ff[i] <= HASH_INIT[i];
         end
      end else begin
         if (cmd.push) begin
            fill_ff <= fill_ff + 6'd1;
         end
         if (cmd.count_inc) begin
            count_ff <= count_ff + 64'd1;
         end
         if (cmd.hash_update) begin
            for (int i = 0; i < NUM_HASH; i++) begin
               hash_ff[i] <= hash_ff[i] + work_ff[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         acc_ff <= packed_word[23:0];
      end
      if (cmd.push && (fill_ff[1:0] == 2'b11)) begin
         for (int i = 0; i < WIN_LEN - 1; i++) begin
            win_ff[i] <= win_ff[i+1];
         end
         win_ff[WIN_LEN-1] <= packed_word;
      end else if (cmd.round_en) begin
         for (int i = 0; i < WIN_LEN - 1; i++) begin
            win_ff[i] <= win_ff[i+1];
         end
         win_ff[WIN_LEN-1] <= sched_new;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_work) begin
         for (int i = 0; i < NUM_HASH; i++) begin
            work_ff[i] <= hash_ff[i];
         end
      end else if (cmd.round_en) begin
         work_ff[7] <= work_ff[6];
         work_ff[6] <= work_ff[5];
         work_ff[5] <= work_ff[4];
         work_ff[4] <= work_ff[3] + t1;
         work_ff[3] <= work_ff[2];
         work_ff[2] <= work_ff[1];
         work_ff[1] <= work_ff[0];
         work_ff[0] <= t1 + t2;
      end
   end

   assign status.fill          = fill_ff;
   assign rsp_item.digest_word = hash_ff[cmd.word];
   assign rsp_item.word_index  = cmd.word;
   assign rsp_item.last_word   = (cmd.word == LAST_WORD);

endmodule

FILE: src/sha256_ctrl.sv
module sha256_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   byte_present,
   input  logic                   end_of_message,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  sha256_pkg::status_type status,
   output sha256_pkg::cmd_type    cmd
);
   import sha256_pkg::*;

   state_type  state_ff, state_in;
   logic [5:0] round_ff, round_in;
   logic [2:0] word_ff, word_in;
   logic       end_pending_ff, end_pending_in;
   logic       pad_started_ff, pad_started_in;
   logic       final_ff, final_in;
   logic       block_full;

   assign block_full = (status.fill == LAST_FILL);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         round_ff       <= '0;
         word_ff        <= '0;
         end_pending_ff <= 1'b0;
         pad_started_ff <= 1'b0;
         final_ff       <= 1'b0;
      end else begin
         state_ff       <= state_in;
         round_ff       <= round_in;
         word_ff        <= word_in;
         end_pending_ff <= end_pending_in;
         pad_started_ff <= pad_started_in;
         final_ff       <= final_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      round_in       = round_ff;
      word_in        = word_ff;
      end_pending_in = end_pending_ff;
      pad_started_in = pad_started_ff;
      final_in       = final_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (byte_present && block_full) begin
                  state_in       = S_COMPRESS;
                  end_pending_in = end_of_message;
               end else if (end_of_message) begin
                  state_in = S_PAD_80;
               end
            end
         end
         S_PAD_80: begin
            pad_started_in = 1'b1;
            state_in       = block_full ? S_COMPRESS : S_PAD_ZERO;
         end
         S_PAD_ZERO: begin
            if (status.fill == LEN_FILL) begin
               state_in = S_PAD_LEN;
            end else if (block_full) begin
               state_in = S_COMPRESS;
            end
         end
         S_PAD_LEN: begin
            if (block_full) begin
               final_in = 1'b1;
               state_in = S_COMPRESS;
            end
         end
         S_COMPRESS: begin
            round_in = round_ff + 6'd1;
            if (round_ff == LAST_ROUND) begin
               state_in = S_UPDATE;
            end
         end
         S_UPDATE: begin
            if (final_ff) begin
               state_in = S_OUTPUT;
            end else if (pad_started_ff) begin
               state_in = S_PAD_ZERO;
            end else if (end_pending_ff) begin
               state_in = S_PAD_80;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_OUTPUT: begin
            if (rsp_ready) begin
               word_in = word_ff + 3'd1;
               if (word_ff == LAST_WORD) begin
                  state_in       = S_IDLE;
                  end_pending_in = 1'b0;
                  pad_started_in = 1'b0;
                  final_in       = 1'b0;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready     = 1'b0;
      rsp_valid     = 1'b0;
      cmd           = '0;
      cmd.byte_sel  = BSEL_MSG;
      cmd.round     = round_ff;
      cmd.word      = word_ff;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid && byte_present) begin
               cmd.push      = 1'b1;
               cmd.count_inc = 1'b1;
               cmd.load_work = block_full;
            end
         end
         S_PAD_80: begin
            cmd.push      = 1'b1;
            cmd.byte_sel  = BSEL_PAD80;
            cmd.load_work = block_full;
         end
         S_PAD_ZERO: begin
            if (status.fill != LEN_FILL) begin
               cmd.push      = 1'b1;
               cmd.byte_sel  = BSEL_ZERO;
               cmd.load_work = block_full;
            end
         end
         S_PAD_LEN: begin
            cmd.push      = 1'b1;
            cmd.byte_sel  = BSEL_LEN;
            cmd.load_work = block_full;
         end
         S_COMPRESS: begin
            cmd.round_en = 1'b1;
         end
         S_UPDATE: begin
            cmd.hash_update = 1'b1;
         end
         S_OUTPUT: begin
            rsp_valid = 1'b1;
            cmd.clear = rsp_ready && (word_ff == LAST_WORD);
         end
         default: begin
            cmd.clear = 1'b0;
         end
      endcase
   end

endmodule

FILE: src/sha256_message_digest_top.sv
// SHA-256 streaming digest, one message byte per beat.
// Each full 64-byte block is then compressed while req_ready stays low
// (64 rounds on the single round unit plus one hash update).
// End of message: the 0x80 byte and zero pad bytes up to slot 56, a pause with no push,
// then the length bytes in slots 56..63, one or two compressions, then 8 digest beats,
// one per cycle while rsp_ready is high.
// Synchronous active-high reset loads the initial hash and clears length and fill.
module sha256_message_digest_top (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  sha256_pkg::req_type req_item,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output sha256_pkg::rsp_type rsp_item
);
   import sha256_pkg::*;

   cmd_type    cmd;
   status_type status;

   sha256_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .byte_present   (req_item.byte_present),
      .end_of_message (req_item.end_of_message),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .status         (status),
      .cmd            (cmd)
   );

   sha256_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .msg_byte (req_item.data_byte),
      .status   (status),
      .rsp_item (rsp_item)
   );

endmodule
